// ===== design/html_entity_escaper_core_defines.svh =====
// Assertion macros for the HTML entity escaper core.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef HTML_ENTITY_ESCAPER_CORE_DEFINES_SVH
`define HTML_ENTITY_ESCAPER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HEE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HEE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hee_pkg.sv =====
// Shared types, constants and the entity name table for the escaper.
// No dependencies; imported by every module of the core.
package hee_pkg;

  localparam int unsigned NameMax  = 6;
  localparam int unsigned NameBits = 8 * NameMax;

  localparam logic [7:0] CharAmp  = 8'h26;
  localparam logic [7:0] CharSemi = 8'h3B;

  // One classified input byte, as it travels through the queue.
  typedef struct packed {
    logic                hit;   // byte is replaced by an entity
    logic [2:0]          len;   // name length, 2..6
    logic [NameBits-1:0] name;  // name, first char in the highest used byte
    logic [7:0]          raw;   // the byte itself
  } hee_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } hee_q_status_t;

  typedef struct packed {
    logic pop;
    logic mid_run;
  } hee_back_status_t;

  // Entity name for a byte, zero-padded at the top; all zero on pass-through.
  function automatic logic [NameBits-1:0] entity_name(input logic [7:0] b);
    logic [NameBits-1:0] nm;
    nm = '0;
    case (b)
      8'd38:  nm = NameBits'("amp");
      8'd60:  nm = NameBits'("lt");
      8'd62:  nm = NameBits'("gt");
      8'd34:  nm = NameBits'("quot");
      8'd160: nm = NameBits'("nbsp");
      8'd161: nm = NameBits'("iexcl");
      8'd162: nm = NameBits'("cent");
      8'd163: nm = NameBits'("pound");
      8'd164: nm = NameBits'("curren");
      8'd165: nm = NameBits'("yen");
      8'd166: nm = NameBits'("brvbar");
      8'd167: nm = NameBits'("sect");
      8'd168: nm = NameBits'("uml");
      8'd169: nm = NameBits'("copy");
      8'd170: nm = NameBits'("ordf");
      8'd171: nm = NameBits'("laquo");
      8'd172: nm = NameBits'("not");
      8'd173: nm = NameBits'("shy");
      8'd174: nm = NameBits'("reg");
      8'd175: nm = NameBits'("macr");
      8'd176: nm = NameBits'("deg");
      8'd177: nm = NameBits'("plusmn");
      8'd178: nm = NameBits'("sup2");
      8'd179: nm = NameBits'("sup3");
      8'd180: nm = NameBits'("acute");
      8'd181: nm = NameBits'("micro");
      8'd182: nm = NameBits'("para");
      8'd183: nm = NameBits'("middot");
      8'd184: nm = NameBits'("cedil");
      8'd185: nm = NameBits'("sup1");
      8'd186: nm = NameBits'("ordm");
      8'd187: nm = NameBits'("raquo");
      8'd188: nm = NameBits'("frac14");
      8'd189: nm = NameBits'("frac12");
      8'd190: nm = NameBits'("frac34");
      8'd191: nm = NameBits'("iquest");
      8'd192: nm = NameBits'("Agrave");
      8'd193: nm = NameBits'("Aacute");
      8'd194: nm = NameBits'("Acirc");
      8'd195: nm = NameBits'("Atilde");
      8'd196: nm = NameBits'("Auml");
      8'd197: nm = NameBits'("Aring");
      8'd198: nm = NameBits'("AElig");
      8'd199: nm = NameBits'("Ccedil");
      8'd200: nm = NameBits'("Egrave");
      8'd201: nm = NameBits'("Eacute");
      8'd202: nm = NameBits'("Ecirc");
      8'd203: nm = NameBits'("Euml");
      8'd204: nm = NameBits'("Igrave");
      8'd205: nm = NameBits'("Iacute");
      8'd206: nm = NameBits'("Icirc");
      8'd207: nm = NameBits'("Iuml");
      8'd208: nm = NameBits'("ETH");
      8'd209: nm = NameBits'("Ntilde");
      8'd210: nm = NameBits'("Ograve");
      8'd211: nm = NameBits'("Oacute");
      8'd212: nm = NameBits'("Ocirc");
      8'd213: nm = NameBits'("Otilde");
      8'd214: nm = NameBits'("Ouml");
      8'd215: nm = NameBits'("times");
      8'd216: nm = NameBits'("Oslash");
      8'd217: nm = NameBits'("Ugrave");
      8'd218: nm = NameBits'("Uacute");
      8'd219: nm = NameBits'("Ucirc");
      8'd220: nm = NameBits'("Uuml");
      8'd221: nm = NameBits'("Yacute");
      8'd222: nm = NameBits'("THORN");
      8'd223: nm = NameBits'("szlig");
      8'd224: nm = NameBits'("agrave");
      8'd225: nm = NameBits'("aacute");
      8'd226: nm = NameBits'("acirc");
      8'd227: nm = NameBits'("atilde");
      8'd228: nm = NameBits'("auml");
      8'd229: nm = NameBits'("aring");
      8'd230: nm = NameBits'("aelig");
      8'd231: nm = NameBits'("ccedil");
      8'd232: nm = NameBits'("egrave");
      8'd233: nm = NameBits'("eacute");
      8'd234: nm = NameBits'("ecirc");
      8'd235: nm = NameBits'("euml");
      8'd236: nm = NameBits'("igrave");
      8'd237: nm = NameBits'("iacute");
      8'd238: nm = NameBits'("icirc");
      8'd239: nm = NameBits'("iuml");
      8'd240: nm = NameBits'("eth");
      8'd241: nm = NameBits'("ntilde");
      8'd242: nm = NameBits'("ograve");
      8'd243: nm = NameBits'("oacute");
      8'd244: nm = NameBits'("ocirc");
      8'd245: nm = NameBits'("otilde");
      8'd246: nm = NameBits'("ouml");
      8'd247: nm = NameBits'("divide");
      8'd248: nm = NameBits'("oslash");
      8'd249: nm = NameBits'("ugrave");
      8'd250: nm = NameBits'("uacute");
      8'd251: nm = NameBits'("ucirc");
      8'd252: nm = NameBits'("uuml");
      8'd253: nm = NameBits'("yacute");
      8'd254: nm = NameBits'("thorn");
      8'd255: nm = NameBits'("yuml");
      default: nm = '0;
    endcase
    return nm;
  endfunction

endpackage

// ===== design/hee_front.sv =====
// Front end: takes input bytes and classifies them into queue items.
// Depends on hee_pkg for the item type and the name table.
module hee_front
  import hee_pkg::*;
(
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    in_byte_i,
  input  hee_q_status_t q_status_i,
  output logic          push_o,
  output hee_item_t     item_o
);

  logic [NameBits-1:0] name;
  logic [2:0]          len;

  always_comb begin
    name = entity_name(in_byte_i);
    len  = 3'd0;
    // names are padded with zero bytes at the top, so count the used ones
    for (int i = 0; i < NameMax; i++) begin
      if (name[i*8 +: 8] != 8'h00) begin
        len = len + 3'd1;
      end
    end
  end

  assign item_o.hit  = (len != 3'd0);
  assign item_o.len  = len;
  assign item_o.name = name;
  assign item_o.raw  = in_byte_i;

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

endmodule

// ===== design/hee_fifo.sv =====
// Two-entry queue of classified items between front and back ends.
// Depends on hee_pkg for the item and status types.
module hee_fifo
  import hee_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hee_item_t     push_item_i,
  input  logic          pop_i,
  output hee_item_t     head_o,
  output hee_q_status_t status_o
);

  hee_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.empty = (cnt_q == 2'd0);
  assign status_o.full  = (cnt_q == 2'd2);

endmodule

// ===== design/hee_back.sv =====
// Back end: walks the head item one character per cycle into the output register unless stalled.
// Depends on hee_pkg for the item type and character constants.
module hee_back
  import hee_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hee_item_t        head_i,
  input  hee_q_status_t    q_status_i,
  output hee_back_status_t status_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_char_o,
  output logic             last_of_run_o
);

  logic [2:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;

  logic [2:0] last_pos;
  logic [2:0] name_idx;
  logic       is_last;
  logic       advance;
  logic       load;

  always_comb begin
    last_pos = head_i.hit ? 3'(head_i.len + 3'd1) : 3'd0;
    is_last  = (pos_q == last_pos);
    // first name char sits in the highest used byte
    name_idx = head_i.len - pos_q;
    advance  = !out_valid_q || !out_stall_i;
    load     = advance && !q_status_i.empty;

    if (!head_i.hit) begin
      out_char_d = head_i.raw;
    end else if (pos_q == 3'd0) begin
      out_char_d = CharAmp;
    end else if (is_last) begin
      out_char_d = CharSemi;
    end else begin
      out_char_d = head_i.name[{name_idx, 3'b000} +: 8];
    end
    out_last_d = is_last;

    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    if (load) begin
      pos_d       = is_last ? 3'd0 : 3'(pos_q + 3'd1);
      out_valid_d = 1'b1;
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  assign status_o.pop     = load && is_last;
  assign status_o.mid_run = (pos_q != 3'd0);

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_of_run_o = out_last_q;

endmodule

// ===== design/html_entity_escaper_core.sv =====
// HTML entity escaper core: one byte in, a run of 1 to 8 characters out.
// A byte taken is written into the queue; its characters then pass through the output register.
// One output character per cycle while out_stall_i is low, set by the single character
// output register of the back end.
// A two-entry queue lets input be taken while a run is still being sent.
// Reset (rst_ni low, asynchronous) empties the queue and the output register.
`include "html_entity_escaper_core_defines.svh"

module html_entity_escaper_core
  import hee_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_of_run_o
);

  hee_item_t        push_item;
  hee_item_t        head;
  hee_q_status_t    q_status;
  hee_back_status_t back_status;
  logic             push;

  hee_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .q_status_i (q_status),
    .push_o     (push),
    .item_o     (push_item)
  );

  hee_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (back_status.pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  hee_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .status_o      (back_status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

  `HEE_ASSERT_NOW(a_q_sane, 1'b1, !(q_status.full && q_status.empty), "queue full and empty")
  `HEE_ASSERT_NOW(a_mid_run_has_item, back_status.mid_run, !q_status.empty, "run without item")
  `HEE_ASSERT_NEXT(a_pop_sends_last, back_status.pop, out_valid_o && last_of_run_o,
                   "item retired without last character")

endmodule

// ===== dv/tb.sv =====
// Testbench for html_entity_escaper_core: random and directed bytes in, escaped runs out.
// Predicts each run from its own Latin-1 entity table and checks every character.
// Depends on hee_pkg and the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hee_pkg::*;

  localparam logic [7:0] ChLt      = 8'h3C;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChQuot    = 8'h22;
  localparam logic [7:0] LatFirst  = 8'd160;
  localparam int         CycleLimit = 200000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } esc_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_char_o;
  logic       last_of_run_o;

  esc_char_t esc_q[$];
  int        gap_max;
  int        n_err;
  int        n_in;
  int        n_out;
  int        n_runs;
  int        cycle_cnt;

  string latin_names [96] = '{
    "nbsp", "iexcl", "cent", "pound", "curren", "yen", "brvbar", "sect",
    "uml", "copy", "ordf", "laquo", "not", "shy", "reg", "macr",
    "deg", "plusmn", "sup2", "sup3", "acute", "micro", "para", "middot",
    "cedil", "sup1", "ordm", "raquo", "frac14", "frac12", "frac34", "iquest",
    "Agrave", "Aacute", "Acirc", "Atilde", "Auml", "Aring", "AElig", "Ccedil",
    "Egrave", "Eacute", "Ecirc", "Euml", "Igrave", "Iacute", "Icirc", "Iuml",
    "ETH", "Ntilde", "Ograve", "Oacute", "Ocirc", "Otilde", "Ouml", "times",
    "Oslash", "Ugrave", "Uacute", "Ucirc", "Uuml", "Yacute", "THORN", "szlig",
    "agrave", "aacute", "acirc", "atilde", "auml", "aring", "aelig", "ccedil",
    "egrave", "eacute", "ecirc", "euml", "igrave", "iacute", "icirc", "iuml",
    "eth", "ntilde", "ograve", "oacute", "ocirc", "otilde", "ouml", "divide",
    "oslash", "ugrave", "uacute", "ucirc", "uuml", "yacute", "thorn", "yuml"
  };

  html_entity_escaper_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Queue the escaped run that one input byte should produce.
  function automatic void escape_byte(input logic [7:0] b);
    string nm;
    int    i;
    nm = "";
    case (b)
      CharAmp: nm = "amp";
      ChLt:    nm = "lt";
      ChGt:    nm = "gt";
      ChQuot:  nm = "quot";
      default: if (b >= LatFirst) nm = latin_names[b - LatFirst];
    endcase
    if (nm.len() == 0) begin
      esc_q.push_back('{ch: b, last: 1'b1});
    end else begin
      n_runs++;
      esc_q.push_back('{ch: CharAmp, last: 1'b0});
      for (i = 0; i < nm.len(); i++) esc_q.push_back('{ch: nm[i], last: 1'b0});
      esc_q.push_back('{ch: CharSemi, last: 1'b1});
    end
  endfunction

  // Predict on accepted input first, then check the accepted output of the same edge.
  always @(posedge clk_i) begin
    esc_char_t exp_c;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        n_in++;
        escape_byte(in_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        n_out++;
        if (esc_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected char, expected none, got %h last %b",
                   $time, out_char_o, last_of_run_o);
        end else begin
          exp_c = esc_q.pop_front();
          if (out_char_o !== exp_c.ch) begin
            n_err++;
            $display("%0t: out_char mismatch, expected %h, got %h",
                     $time, exp_c.ch, out_char_o);
          end
          if (last_of_run_o !== exp_c.last) begin
            n_err++;
            $display("%0t: last_of_run mismatch, expected %b, got %b",
                     $time, exp_c.last, last_of_run_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout with %0d chars outstanding", $time, esc_q.size());
      $display("tb failed");
      $finish;
    end
  end

  // Output side: stall a random number of cycles before each transaction.
  initial begin
    int n;
    forever begin
      n = $urandom_range(0, gap_max);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Hold valid high after acceptance; the next call either reuses it or drops it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (esc_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: b = 8'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: b = CharAmp;
          1: b = ChLt;
          2: b = ChGt;
          default: b = ChQuot;
        endcase
      end
      default: b = 8'($urandom_range(160, 255));
    endcase
    return b;
  endfunction

  task automatic test_directed();
    logic [7:0] vec [20] = '{
      8'h00, 8'hFF, 8'h7F, 8'h80, 8'h9F, 8'hA0, CharAmp, ChLt, ChGt, ChQuot,
      8'd166, 8'd168, 8'd175, 8'd208, 8'd164, 8'h41, 8'h55, 8'hAA, 8'd177, 8'd240
    };
    gap_max = 19;
    foreach (vec[i]) send_byte(vec[i]);
  endtask

  task automatic test_back_to_back();
    gap_max = 0;
    repeat (20) send_byte(pick_byte());
    gap_max = 19;
  endtask

  // Pause the sender until every queued character has come out, then resume.
  task automatic test_drain_pause();
    repeat (5) send_byte(pick_byte());
    wait_drained();
    repeat (5) send_byte(pick_byte());
  endtask

  task automatic test_random();
    gap_max = 19;
    repeat (60) send_byte(pick_byte());
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = 8'h00;
    out_stall_i = 1'b0;
    gap_max     = 19;
    n_err       = 0;
    n_in        = 0;
    n_out       = 0;
    n_runs      = 0;
    cycle_cnt   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_back_to_back();
    test_drain_pause();
    test_random();

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("bytes in: %0d, chars out: %0d, escaped runs: %0d, errors: %0d",
             n_in, n_out, n_runs, n_err);
    if (n_err == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
